// ===== rtl/pc_stride_prefetcher_defines.svh =====
// Assertion macros used by the checker file of the prefetcher.
`ifndef PC_STRIDE_PREFETCHER_DEFINES_SVH
`define PC_STRIDE_PREFETCHER_DEFINES_SVH

// Checked at every clock edge outside reset.
`define PCSP_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define PCSP_ASSERT_RST(name, prop, msg) \
   name: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== rtl/pcsp_pkg.sv =====
`timescale 1ns / 1ps

package pcsp_pkg;

   localparam int unsigned DEFAULT_ENTRIES = 64;
   localparam int unsigned ADDR_W          = 32;
   localparam int unsigned DEGREE_W        = 5;
   localparam logic [DEGREE_W-1:0] MAX_DEGREE   = 5'd16;
   localparam logic [DEGREE_W-1:0] DEGREE_RESET = 5'd6;

   typedef struct packed {
      logic [ADDR_W-1:0] stride;
      logic [ADDR_W-1:0] last_address;
      logic [ADDR_W-1:0] tag;
   } row_type;

   typedef enum logic {
      ALU_ADD,
      ALU_SUB
   } alu_op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_ALLOC,
      ST_DIFF,
      ST_EMIT
   } state_type;

endpackage

// ===== rtl/pcsp_alu.sv =====
`timescale 1ns / 1ps

module pcsp_alu
   import pcsp_pkg::*;
(
   input  logic [ADDR_W-1:0] op_a,
   input  logic [ADDR_W-1:0] op_b,
   input  alu_op_type        op,
   output logic [ADDR_W-1:0] result
);

   // Both the stride and the running prefetch address wrap modulo 2^32.
   always_comb begin
      unique case (op)
         ALU_ADD: result = op_a + op_b;
         ALU_SUB: result = op_a - op_b;
         default: result = op_a + op_b;
      endcase
   end

endmodule

// ===== rtl/pcsp_table.sv =====
`timescale 1ns / 1ps

module pcsp_table
   import pcsp_pkg::*;
#(
   parameter int unsigned ENTRIES = DEFAULT_ENTRIES
) (
   input  logic                       clock,
   input  logic                       rd_en,
   input  logic [$clog2(ENTRIES)-1:0] rd_row,
   output row_type                    rd_data,
   input  logic                       wr_en,
   input  logic [$clog2(ENTRIES)-1:0] wr_row,
   input  row_type                    wr_data
);

   row_type mem [ENTRIES];
   row_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_row] <= wr_data;
      end
   end

   // The read register holds its value while rd_en is low, so a matched
   // row stays available for the update and the prefetch run.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_row];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/pcsp_seq.sv =====
`timescale 1ns / 1ps

module pcsp_seq
   import pcsp_pkg::*;
#(
   parameter int unsigned ENTRIES = DEFAULT_ENTRIES
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [ADDR_W-1:0]          req_pc,
   input  logic [ADDR_W-1:0]          req_address,
   input  logic                       req_miss,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [ADDR_W-1:0]          rsp_address,
   output logic                       rsp_last,
   input  logic [DEGREE_W-1:0]        degree,
   output logic                       rd_en,
   output logic [$clog2(ENTRIES)-1:0] rd_row,
   input  row_type                    row_q,
   output logic                       wr_en,
   output logic [$clog2(ENTRIES)-1:0] wr_row,
   output row_type                    wr_data,
   output logic [ADDR_W-1:0]          alu_a,
   output logic [ADDR_W-1:0]          alu_b,
   output alu_op_type                 alu_op,
   input  logic [ADDR_W-1:0]          alu_result
);

   localparam int unsigned RW = $clog2(ENTRIES);
   localparam int unsigned CW = $clog2(ENTRIES + 1);

   state_type state_ff, state_in;
   logic [ADDR_W-1:0] pc_ff, pc_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic miss_ff, miss_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic pend_ff, pend_in;
   logic [RW-1:0] rp_ff, rp_in;
   logic [CW-1:0] fill_ff, fill_in;
   logic [ADDR_W-1:0] pf_ff, pf_in;
   logic [DEGREE_W-1:0] cnt_ff, cnt_in;
   logic out_valid_ff, out_valid_in;
   logic [ADDR_W-1:0] out_addr_ff, out_addr_in;
   logic out_last_ff, out_last_in;

   logic match;
   logic more;
   logic diff_zero;
   logic diff_same;
   logic fire;
   logic [DEGREE_W-1:0] num_pf;
   logic [CW-1:0] idx_dec;
   logic [RW-1:0] hit_row;

   // Rows are allocated in order from row 0, so the valid rows are exactly
   // those below the fill count.
   assign match     = pend_ff && (row_q.tag == pc_ff);
   assign more      = idx_ff < fill_ff;
   assign diff_zero = alu_result == '0;
   assign diff_same = alu_result == row_q.stride;
   assign fire      = (state_ff == ST_EMIT) && (!out_valid_ff || rsp_ready);
   assign num_pf    = (degree > MAX_DEGREE) ? MAX_DEGREE : degree;
   assign idx_dec   = idx_ff - CW'(1);
   assign hit_row   = idx_dec[RW-1:0];
   assign rd_row    = idx_ff[RW-1:0];

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (match) state_in = ST_DIFF;
            else if (!more) state_in = ST_ALLOC;
         end
         ST_ALLOC: state_in = ST_IDLE;
         ST_DIFF: begin
            if (!diff_zero && diff_same && miss_ff && (num_pf != '0)) state_in = ST_EMIT;
            else state_in = ST_IDLE;
         end
         ST_EMIT: begin
            if (fire && (cnt_ff == DEGREE_W'(1))) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready   = 1'b0;
      pc_in       = pc_ff;
      addr_in     = addr_ff;
      miss_in     = miss_ff;
      idx_in      = idx_ff;
      pend_in     = 1'b0;
      rp_in       = rp_ff;
      fill_in     = fill_ff;
      pf_in       = pf_ff;
      cnt_in      = cnt_ff;
      out_addr_in = out_addr_ff;
      out_last_in = out_last_ff;
      rd_en       = 1'b0;
      wr_en       = 1'b0;
      wr_row      = rp_ff;
      wr_data     = '{tag: pc_ff, last_address: addr_ff, stride: '0};
      alu_a       = addr_ff;
      alu_b       = row_q.last_address;
      alu_op      = ALU_SUB;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               pc_in   = req_pc;
               addr_in = req_address;
               miss_in = req_miss;
               idx_in  = '0;
            end
         end
         ST_SCAN: begin
            // Compare the row read last cycle while reading the next one.
            if (!match && more) begin
               rd_en   = 1'b1;
               pend_in = 1'b1;
               idx_in  = idx_ff + CW'(1);
            end
         end
         ST_ALLOC: begin
            wr_en = 1'b1;
            rp_in = (rp_ff == RW'(ENTRIES - 1)) ? '0 : rp_ff + RW'(1);
            if (fill_ff != CW'(ENTRIES)) fill_in = fill_ff + CW'(1);
         end
         ST_DIFF: begin
            // A matching stride writes the same value back, so one write
            // covers both the new-stride and the confirmed-stride cases.
            wr_en   = !diff_zero;
            wr_row  = hit_row;
            wr_data = '{tag: row_q.tag, last_address: addr_ff, stride: alu_result};
            pf_in   = addr_ff;
            cnt_in  = num_pf;
         end
         ST_EMIT: begin
            alu_a  = pf_ff;
            alu_b  = row_q.stride;
            alu_op = ALU_ADD;
            if (fire) begin
               pf_in       = alu_result;
               cnt_in      = cnt_ff - DEGREE_W'(1);
               out_addr_in = alu_result;
               out_last_in = cnt_ff == DEGREE_W'(1);
            end
         end
         default: ;
      endcase
      out_valid_in = fire || (out_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         pend_ff      <= 1'b0;
         rp_ff        <= '0;
         fill_ff      <= '0;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         pend_ff      <= pend_in;
         rp_ff        <= rp_in;
         fill_ff      <= fill_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pc_ff       <= pc_in;
      addr_ff     <= addr_in;
      miss_ff     <= miss_in;
      pf_ff       <= pf_in;
      out_addr_ff <= out_addr_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_address = out_addr_ff;
   assign rsp_last    = out_last_ff;

endmodule

// ===== rtl/pc_stride_prefetcher.sv =====
`timescale 1ns / 1ps

// PC-indexed stride prefetcher. Each access transfer (pc, address, miss) is
// looked up by pc in a table of ENTRIES rows held in a memory with one read
// port and one write port, which is scanned one row per cycle from row 0 up
// to the number of rows allocated so far; rows are allocated round robin
// when no row holds the pc. The scan length sets how soon the block is ready
// again for the next access. When the stored stride is confirmed on a cache
// miss, min(degree, 16) prefetch addresses follow, one per cycle through a
// single shared adder, as long as the output transfer is taken at once; the
// final one carries rsp_tlast. The input is not ready while an access is
// scanned or its prefetches issue.
// Write csr_wr_data to set degree (reset value 6) only while the block is idle.
module pc_stride_prefetcher
   import pcsp_pkg::*;
#(
   parameter int unsigned ENTRIES = DEFAULT_ENTRIES
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [63:0]         req_tdata,   // pc [31:0], address [63:32]
   input  logic                req_tuser,   // miss
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [31:0]         rsp_tdata,   // prefetch_address [31:0]
   output logic                rsp_tlast,
   input  logic                csr_wr_en,
   input  logic [DEGREE_W-1:0] csr_wr_data
);

   localparam int unsigned RW = $clog2(ENTRIES);

   logic [DEGREE_W-1:0] degree_ff, degree_in;
   logic rd_en;
   logic [RW-1:0] rd_row;
   row_type row_q;
   logic wr_en;
   logic [RW-1:0] wr_row;
   row_type wr_data;
   logic [ADDR_W-1:0] alu_a;
   logic [ADDR_W-1:0] alu_b;
   alu_op_type alu_op;
   logic [ADDR_W-1:0] alu_result;

   assign degree_in = csr_wr_en ? csr_wr_data : degree_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         degree_ff <= DEGREE_RESET;
      end else begin
         degree_ff <= degree_in;
      end
   end

   pcsp_seq #(
      .ENTRIES(ENTRIES)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_pc     (req_tdata[31:0]),
      .req_address(req_tdata[63:32]),
      .req_miss   (req_tuser),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_address(rsp_tdata),
      .rsp_last   (rsp_tlast),
      .degree     (degree_ff),
      .rd_en      (rd_en),
      .rd_row     (rd_row),
      .row_q      (row_q),
      .wr_en      (wr_en),
      .wr_row     (wr_row),
      .wr_data    (wr_data),
      .alu_a      (alu_a),
      .alu_b      (alu_b),
      .alu_op     (alu_op),
      .alu_result (alu_result)
   );

   pcsp_table #(
      .ENTRIES(ENTRIES)
   ) u_table (
      .clock  (clock),
      .rd_en  (rd_en),
      .rd_row (rd_row),
      .rd_data(row_q),
      .wr_en  (wr_en),
      .wr_row (wr_row),
      .wr_data(wr_data)
   );

   pcsp_alu u_alu (
      .op_a  (alu_a),
      .op_b  (alu_b),
      .op    (alu_op),
      .result(alu_result)
   );

endmodule

// ===== rtl/pcsp_checker.sv =====
`timescale 1ns / 1ps
`include "pc_stride_prefetcher_defines.svh"

module pcsp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tlast
);

   // A stalled prefetch transfer keeps its address and marker.
   `PCSP_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "rsp changed while stalled")

   // Reset leaves no prefetch pending.
   `PCSP_ASSERT_RST(a_reset_empty, reset |=> !rsp_tvalid, "rsp valid after reset")

   // More prefetches of the same access are still due, so no access is taken.
   `PCSP_ASSERT(a_busy_in_run, rsp_tvalid && !rsp_tlast |-> !req_tready, "ready during a prefetch run")

   // Every access needs at least a table lookup before the next one.
   `PCSP_ASSERT(a_no_back_to_back, req_tvalid && req_tready |=> !req_tready, "ready right after an access")

endmodule

bind pc_stride_prefetcher pcsp_checker u_checker (.*);
